### rtl/clu_pkg.sv
// Shared constants and types for the cluster labeler.
package clu_pkg;
  localparam int unsigned SITES_DEF     = 1024;
  localparam int unsigned NEIGHBORS_DEF = 4;
  localparam int unsigned FIELD_SLOTS   = 4;
  localparam int unsigned LABEL_W       = 11;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned LINK_W        = 12;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Request from the sequencer to the class memory.
  typedef struct packed {
    logic               rd_en;
    logic [LABEL_W-1:0] rd_addr;
    logic               wr_en;
    logic [LABEL_W-1:0] wr_addr;
    logic [LINK_W-1:0]  wr_data;
  } cls_req_t;
endpackage

### rtl/clu_class_mem.sv
// Class link memory: one entry per label, redirect flag plus target label.
module clu_class_mem import clu_pkg::*; #(
  parameter int unsigned SITES = SITES_DEF
) (
  input  logic              clk_i,
  input  cls_req_t          req_i,
  output logic [LINK_W-1:0] rd_data_o
);
  localparam int unsigned DEPTH = SITES + 2;
  logic [LINK_W-1:0] mem [DEPTH];

  // Labels beyond the table read as a root entry of zero and are not written.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && 32'(req_i.wr_addr) < DEPTH) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      if (32'(req_i.rd_addr) < DEPTH) rd_data_o <= mem[req_i.rd_addr];
      else rd_data_o <= '0;
    end
  end
endmodule

### rtl/clu_site_mem.sv
// Per-site memory holding each site's key and provisional label.
module clu_site_mem import clu_pkg::*; #(
  parameter int unsigned SITES = SITES_DEF,
  parameter int unsigned AW    = $clog2(SITES)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [KEY_W-1:0]   wr_key_i,
  input  logic [LABEL_W-1:0] wr_label_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [KEY_W-1:0]   rd_key_o,
  output logic [LABEL_W-1:0] rd_label_o
);
  logic [KEY_W+LABEL_W-1:0] mem [SITES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= {wr_key_i, wr_label_i};
    if (rd_en_i) {rd_key_o, rd_label_o} <= mem[rd_addr_i];
  end
endmodule

### rtl/cluster_labeler_union_find.sv
// Top level of the union-find cluster labeler: command sequencer and memories.
//
// Each command is one transfer taken while busy is low. Its single result
// appears on label_o, next_label_o and error_o for exactly one cycle with
// done_o high, and the receiver cannot stall it. A restart, an unused
// command and a rejected add or read answer from S_RESP, and the add of
// site 0 goes straight to S_FIN. A read follows the chain from the site's
// label to its root, where every hop is one class memory read. An add of a
// later site visits each neighbor slot in turn: a slot is skipped, its key
// differs, or it links once its chain has been followed to the root. A
// merge of two or more links then writes each linked root back in S_MERGE.
// Both memories have registered read outputs. cfg_valid_i writes the key
// mask; it should only be written while the block is idle.
module cluster_labeler_union_find import clu_pkg::*; #(
  parameter int unsigned SITES     = SITES_DEF,
  parameter int unsigned NEIGHBORS = NEIGHBORS_DEF,
  parameter int unsigned AW        = $clog2(SITES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [KEY_W-1:0]   site_key_i,
  input  logic [IDX_W-1:0]   neighbor_a_i,
  input  logic [IDX_W-1:0]   neighbor_b_i,
  input  logic [IDX_W-1:0]   neighbor_c_i,
  input  logic [IDX_W-1:0]   neighbor_d_i,
  input  logic [3:0]         neighbor_valid_i,
  input  logic [IDX_W-1:0]   read_site_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [KEY_W-1:0]   cfg_data_i,
  output logic               done_o,
  output logic [LABEL_W-1:0] label_o,
  output logic [LABEL_W-1:0] next_label_o,
  output logic               error_o
);
  localparam int unsigned NSLOT = (NEIGHBORS < FIELD_SLOTS) ? NEIGHBORS : FIELD_SLOTS;
  localparam int unsigned SW    = $clog2(FIELD_SLOTS + 1);
  localparam int unsigned CW    = $clog2(SITES + 3) + 1;
  localparam int unsigned CNT_W = $clog2(SITES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NBR    = 4'd1;  // issue site read for a slot
  localparam logic [3:0] S_NBRW   = 4'd2;  // site data arrives
  localparam logic [3:0] S_CHK    = 4'd3;  // compare key, start chain
  localparam logic [3:0] S_FIND   = 4'd4;  // class entry arrives
  localparam logic [3:0] S_MERGE  = 4'd5;  // write roots back
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_RDW    = 4'd7;
  localparam logic [3:0] S_RDCHK  = 4'd8;
  localparam logic [3:0] S_RESP   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [KEY_W-1:0] mask_q;
  logic [CNT_W-1:0] added_q, added_d;
  logic [LABEL_W-1:0] fresh_q, fresh_d;
  logic [1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] nbr_q [FIELD_SLOTS];
  logic [3:0] nvalid_q;
  logic [SW-1:0] slot_q, slot_d, wslot_q, wslot_d;
  logic [SW-1:0] linked_q, linked_d;
  logic [LABEL_W-1:0] roots_q [FIELD_SLOTS];
  logic [LABEL_W-1:0] roots_d [FIELD_SLOTS];
  logic [LABEL_W-1:0] first_q, first_d, minr_q, minr_d, cur_q, cur_d;
  logic [CW-1:0] steps_q, steps_d;
  logic [LABEL_W-1:0] lab_q, lab_d;
  logic err_q, err_d, done_d;

  cls_req_t creq;
  logic [LINK_W-1:0] cdata;
  logic s_wr, s_rd;
  logic [AW-1:0] s_raddr;
  logic [LABEL_W-1:0] s_wlabel;
  logic [KEY_W-1:0] s_key;
  logic [LABEL_W-1:0] s_label;

  clu_class_mem #(.SITES(SITES)) u_class (.clk_i, .req_i(creq), .rd_data_o(cdata));
  clu_site_mem #(.SITES(SITES), .AW(AW)) u_site (
    .clk_i, .wr_en_i(s_wr), .wr_addr_i(added_q[AW-1:0]), .wr_key_i(key_q),
    .wr_label_i(s_wlabel), .rd_en_i(s_rd), .rd_addr_i(s_raddr),
    .rd_key_o(s_key), .rd_label_o(s_label)
  );

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  logic cur_slot_ok;
  logic [IDX_W-1:0] cur_nbr;
  assign cur_nbr = nbr_q[slot_q[1:0]];
  assign cur_slot_ok = nvalid_q[slot_q[1:0]] && (17'(cur_nbr) < 17'(added_q));

  always_comb begin
    state_d = state_q; added_d = added_q; fresh_d = fresh_q;
    slot_d = slot_q; wslot_d = wslot_q; linked_d = linked_q;
    roots_d = roots_q; first_d = first_q; minr_d = minr_q; cur_d = cur_q;
    steps_d = steps_q; lab_d = lab_q; err_d = err_q; done_d = 1'b0;
    creq = '0; s_wr = 1'b0; s_rd = 1'b0; s_raddr = '0; s_wlabel = lab_q;
    case (state_q)
      S_IDLE: ;
      S_NBR: begin
        if (32'(slot_q) >= NSLOT) begin
          if (linked_q == '0) begin
            lab_d = fresh_q;
            creq.wr_en = 1'b1; creq.wr_addr = fresh_q;
            creq.wr_data = {1'b0, fresh_q};
            fresh_d = fresh_q + 1'b1;
            state_d = S_FIN;
          end else if (linked_q == SW'(1)) begin
            lab_d = first_q; state_d = S_FIN;
          end else begin
            lab_d = minr_q; wslot_d = '0; state_d = S_MERGE;
          end
        end else if (cur_slot_ok) begin
          s_rd = 1'b1; s_raddr = AW'(cur_nbr); state_d = S_NBRW;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_NBRW: state_d = S_CHK;
      S_CHK: begin
        if (((key_q ^ s_key) & mask_q) != '0) begin
          slot_d = slot_q + 1'b1; state_d = S_NBR;
        end else begin
          if (linked_q == '0) first_d = s_label;
          cur_d = s_label; steps_d = '0;
          creq.rd_en = 1'b1; creq.rd_addr = s_label;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (cdata[LINK_W-1] && 32'(steps_q) < SITES + 2) begin
          cur_d = cdata[LABEL_W-1:0]; steps_d = steps_q + 1'b1;
          creq.rd_en = 1'b1; creq.rd_addr = cdata[LABEL_W-1:0];
        end else if (cmd_q == CMD_READ) begin
          lab_d = cur_q; done_d = 1'b1; state_d = S_IDLE;
        end else begin
          roots_d[linked_q[1:0]] = cur_q;
          if (linked_q == '0 || cur_q < minr_q) minr_d = cur_q;
          linked_d = linked_q + 1'b1;
          slot_d = slot_q + 1'b1;
          state_d = S_NBR;
        end
      end
      S_MERGE: begin
        if (wslot_q == linked_q) begin
          state_d = S_FIN;
        end else begin
          creq.wr_en = 1'b1; creq.wr_addr = roots_q[wslot_q[1:0]];
          creq.wr_data = (roots_q[wslot_q[1:0]] == minr_q) ?
                         {1'b0, minr_q} : {1'b1, minr_q};
          wslot_d = wslot_q + 1'b1;
        end
      end
      S_FIN: begin
        s_wr = 1'b1; added_d = added_q + 1'b1;
        done_d = 1'b1; state_d = S_IDLE;
      end
      S_RDW: state_d = S_RDCHK;
      S_RDCHK: begin
        cur_d = s_label; steps_d = '0;
        creq.rd_en = 1'b1; creq.rd_addr = s_label;
        state_d = S_FIND;
      end
      S_RESP: begin done_d = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase

    if (state_q == S_IDLE && start) begin
      lab_d = '0; err_d = 1'b0; linked_d = '0; slot_d = '0;
      case (command_i)
        CMD_ADD: begin
          if (32'(added_q) >= SITES) begin
            err_d = 1'b1; state_d = S_RESP;
          end else if (added_q == '0) begin
            lab_d = LABEL_W'(1);
            creq.wr_en = 1'b1; creq.wr_addr = LABEL_W'(1);
            creq.wr_data = LINK_W'(1);
            state_d = S_FIN;
          end else begin
            state_d = S_NBR;
          end
        end
        CMD_READ: begin
          if (17'(read_site_i) >= 17'(added_q)) begin
            err_d = 1'b1; state_d = S_RESP;
          end else begin
            s_rd = 1'b1; s_raddr = AW'(read_site_i); state_d = S_RDW;
          end
        end
        CMD_RESTART: begin
          added_d = '0; fresh_d = LABEL_W'(2); state_d = S_RESP;
        end
        default: state_d = S_RESP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mask_q <= '1; added_q <= '0;
      fresh_q <= LABEL_W'(2); done_o <= 1'b0;
    end else begin
      state_q <= state_d; added_q <= added_d; fresh_q <= fresh_d;
      done_o <= done_d;
      if (cfg_valid_i) mask_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= command_i; key_q <= site_key_i;
      nbr_q[0] <= neighbor_a_i; nbr_q[1] <= neighbor_b_i;
      nbr_q[2] <= neighbor_c_i; nbr_q[3] <= neighbor_d_i;
      nvalid_q <= neighbor_valid_i;
    end
    slot_q <= slot_d; wslot_q <= wslot_d; linked_q <= linked_d;
    roots_q <= roots_d; first_q <= first_d; minr_q <= minr_d;
    cur_q <= cur_d; steps_q <= steps_d; lab_q <= lab_d; err_q <= err_d;
    if (done_d) begin
      label_o <= lab_d; next_label_o <= fresh_d; error_o <= err_d;
    end
  end
endmodule

### tb/sv/clu_checker.sv
// Scoreboard for the cluster labeler: tracks labels and class links and checks every result.
module clu_checker import clu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         command_i,
  input  logic [KEY_W-1:0]   site_key_i,
  input  logic [IDX_W-1:0]   neighbor_a_i,
  input  logic [IDX_W-1:0]   neighbor_b_i,
  input  logic [IDX_W-1:0]   neighbor_c_i,
  input  logic [IDX_W-1:0]   neighbor_d_i,
  input  logic [3:0]         neighbor_valid_i,
  input  logic [IDX_W-1:0]   read_site_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [KEY_W-1:0]   cfg_data_i,
  input  logic               done_i,
  input  logic [LABEL_W-1:0] label_i,
  input  logic [LABEL_W-1:0] next_label_i,
  input  logic               error_i,
  output int                 pending_o,
  output int                 fails_o
);
  localparam int unsigned CLASS_DEPTH = SITES_DEF + 2;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] next_label;
    logic               error;
  } label_result_t;

  logic [KEY_W-1:0]   key_mask;
  logic [KEY_W-1:0]   site_keys [SITES_DEF];
  logic [LABEL_W-1:0] site_labels [SITES_DEF];
  logic [LINK_W-1:0]  class_links [CLASS_DEPTH];
  int unsigned        sites_added;
  logic [LABEL_W-1:0] fresh_label;
  label_result_t      expected_labels [$];

  assign pending_o = expected_labels.size();

  function automatic logic [LABEL_W-1:0] root_of(logic [LABEL_W-1:0] lab);
    int unsigned steps;
    logic [LINK_W-1:0] e;
    steps = 0;
    e = (lab < CLASS_DEPTH) ? class_links[lab] : '0;
    while (e[LINK_W-1] && steps < CLASS_DEPTH) begin
      lab = e[LABEL_W-1:0];
      e = (lab < CLASS_DEPTH) ? class_links[lab] : '0;
      steps++;
    end
    return lab;
  endfunction

  function automatic void set_link(logic [LABEL_W-1:0] lab, logic [LINK_W-1:0] v);
    if (lab < CLASS_DEPTH) class_links[lab] = v;
  endfunction

  // Adds the next site and returns its provisional label.
  function automatic logic [LABEL_W-1:0] add_site();
    int unsigned idx, linked;
    logic [IDX_W-1:0] nb [FIELD_SLOTS];
    logic [LABEL_W-1:0] roots [FIELD_SLOTS];
    logic [LABEL_W-1:0] first, minr, lab;
    idx = sites_added;
    nb[0] = neighbor_a_i;
    nb[1] = neighbor_b_i;
    nb[2] = neighbor_c_i;
    nb[3] = neighbor_d_i;
    linked = 0;
    first = '0;
    minr = '0;
    site_keys[idx] = site_key_i;
    if (idx == 0) begin
      lab = LABEL_W'(1);
      set_link(LABEL_W'(1), LINK_W'(1));
    end else begin
      for (int k = 0; k < FIELD_SLOTS && k < NEIGHBORS_DEF; k++) begin
        if (!neighbor_valid_i[k] || nb[k] >= idx) continue;
        if (((site_key_i ^ site_keys[nb[k]]) & key_mask) != 0) continue;
        if (linked == 0) first = site_labels[nb[k]];
        roots[linked] = root_of(site_labels[nb[k]]);
        if (linked == 0 || roots[linked] < minr) minr = roots[linked];
        linked++;
      end
      if (linked == 0) begin
        lab = fresh_label;
        set_link(lab, LINK_W'(lab));
        fresh_label = fresh_label + 1'b1;
      end else if (linked == 1) begin
        lab = first;
      end else begin
        // Merge: the smallest root stays a root, the others point to it.
        for (int k = 0; k < linked; k++) begin
          if (roots[k] == minr) set_link(roots[k], LINK_W'(roots[k]));
          else set_link(roots[k], {1'b1, minr});
        end
        lab = minr;
      end
    end
    site_labels[idx] = lab;
    sites_added = idx + 1;
    return lab;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    label_result_t want, got;
    if (!rst_ni) begin
      key_mask = '1;
      sites_added = 0;
      fresh_label = LABEL_W'(2);
      fails_o <= 0;
      expected_labels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) key_mask = cfg_data_i;
      if (done_i) begin
        got = '{label_i, next_label_i, error_i};
        if (expected_labels.size() == 0) begin
          $display("%0t: result with none expected: label %0d next %0d error %0b",
                   $time, label_i, next_label_i, error_i);
          fails_o <= fails_o + 1;
        end else begin
          want = expected_labels.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected label %0d next %0d error %0b, got %0d %0d %0b",
                     $time, want.label, want.next_label, want.error,
                     got.label, got.next_label, got.error);
            fails_o <= fails_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        want = '{'0, '0, 1'b0};
        case (command_i)
          CMD_ADD: begin
            if (sites_added >= SITES_DEF) want.error = 1'b1;
            else want.label = add_site();
          end
          CMD_READ: begin
            if (read_site_i >= sites_added) want.error = 1'b1;
            else want.label = root_of(site_labels[read_site_i]);
          end
          CMD_RESTART: begin
            sites_added = 0;
            fresh_label = LABEL_W'(2);
          end
          default: ;
        endcase
        want.next_label = fresh_label;
        expected_labels.push_back(want);
      end
    end
  end
endmodule

### tb/sv/tb_cluster_labeler_union_find.sv
// Testbench top for the cluster labeler: stimulus, clock, reset and verdict.
module tb_cluster_labeler_union_find;
  import clu_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         command_i;
  logic [KEY_W-1:0]   site_key_i;
  logic [IDX_W-1:0]   neighbor_a_i;
  logic [IDX_W-1:0]   neighbor_b_i;
  logic [IDX_W-1:0]   neighbor_c_i;
  logic [IDX_W-1:0]   neighbor_d_i;
  logic [3:0]         neighbor_valid_i;
  logic [IDX_W-1:0]   read_site_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [KEY_W-1:0]   cfg_data_i;
  logic               done_o;
  logic [LABEL_W-1:0] label_o;
  logic [LABEL_W-1:0] next_label_o;
  logic               error_o;
  int                 pending;
  int                 fails;

  // Number of sites the block holds in the current pass, mirrored here so that
  // neighbor indices and read indices can be aimed at real sites.
  int unsigned        site_count;
  // Burst bookkeeping: items left in the current burst.
  int unsigned        burst_left;
  // Keys used in the current pass; a small set so that neighbors often match.
  logic [KEY_W-1:0]   pass_keys [4];
  int unsigned        row_width;

  cluster_labeler_union_find dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .site_key_i,
    .neighbor_a_i, .neighbor_b_i, .neighbor_c_i, .neighbor_d_i,
    .neighbor_valid_i, .read_site_i, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .done_o, .label_o, .next_label_o, .error_o
  );

  clu_checker checker_inst (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .command_i, .site_key_i,
    .neighbor_a_i, .neighbor_b_i, .neighbor_c_i, .neighbor_d_i,
    .neighbor_valid_i, .read_site_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_data_i, .done_i(done_o), .label_i(label_o), .next_label_i(next_label_o),
    .error_i(error_o), .pending_o(pending), .fails_o(fails)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Issues one command and returns in the time step of the edge that accepts it.
  // Busy only changes on a rising edge, so its value at the falling edge holds
  // through the next rising edge. Before each item the sender may close its
  // burst and sit idle for a random number of cycles.
  task automatic issue(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                       input logic [IDX_W-1:0] na, input logic [IDX_W-1:0] nb,
                       input logic [IDX_W-1:0] nc, input logic [IDX_W-1:0] nd,
                       input logic [3:0] nvalid, input logic [IDX_W-1:0] rsite);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start <= 1'b1;
    command_i <= cmd;
    site_key_i <= key;
    neighbor_a_i <= na;
    neighbor_b_i <= nb;
    neighbor_c_i <= nc;
    neighbor_d_i <= nd;
    neighbor_valid_i <= nvalid;
    read_site_i <= rsite;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (cmd == CMD_ADD && site_count < SITES_DEF) site_count++;
    if (cmd == CMD_RESTART) site_count = 0;
  endtask

  // Issues a command whose fields are all random.
  task automatic issue_noise(input logic [1:0] cmd);
    issue(cmd, $urandom, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
          IDX_W'($urandom), 4'($urandom), IDX_W'($urandom));
  endtask

  // Stops the sender until every result has come back, then lets the block
  // settle. Every command produces a result, so a short margin is enough.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the key mask; only called after drain().
  task automatic write_mask(input logic [KEY_W-1:0] mask);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mask;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_site(input logic [KEY_W-1:0] key, input logic [IDX_W-1:0] na,
                          input logic [IDX_W-1:0] nb, input logic [3:0] nvalid);
    issue(CMD_ADD, key, na, nb, '0, '0, nvalid, '0);
  endtask

  task automatic read_site(input logic [IDX_W-1:0] s);
    issue(CMD_READ, $urandom, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
          IDX_W'($urandom), 4'($urandom), s);
  endtask

  // Picks an earlier site index, or a nearby one that may be the new site or later.
  function automatic logic [IDX_W-1:0] near_site(input int unsigned back);
    return IDX_W'(site_count - back);
  endfunction

  // One random item of a lattice-like pass: mostly adds, with left and upper
  // neighbors from a grid of the chosen row width, a random earlier neighbor
  // and a random or nearby one; the rest are reads, noise and the odd restart.
  task automatic random_item(input bit adds_only);
    int unsigned pick;
    logic [IDX_W-1:0] nc, nd;
    pick = adds_only ? 0 : $urandom_range(0, 99);
    nc = (site_count > 0) ? IDX_W'($urandom_range(0, site_count - 1)) : IDX_W'($urandom);
    nd = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : near_site($urandom_range(0, 3));
    if (pick < 70) begin
      issue(CMD_ADD, pass_keys[$urandom_range(0, 3)], near_site(1), near_site(row_width),
            nc, nd, ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF, IDX_W'($urandom));
    end else if (pick < 92) begin
      read_site(($urandom_range(0, 7) == 0 || site_count == 0) ? IDX_W'($urandom)
                : IDX_W'($urandom_range(0, site_count - 1)));
    end else if (pick < 96) begin
      issue_noise(CMD_UNUSED);
    end else if (pick < 98) begin
      issue_noise(CMD_ADD);
    end else begin
      issue_noise(CMD_RESTART);
    end
  endtask

  // Starts a fresh pass with a new key set and grid width.
  task automatic new_pass();
    pass_keys[0] = $urandom;
    for (int k = 1; k < 4; k++) begin
      pass_keys[k] = pass_keys[0] ^ (32'h1 << $urandom_range(0, 31));
    end
    row_width = $urandom_range(2, 24);
    issue(CMD_RESTART, '0, '0, '0, '0, '0, '0, '0);
  endtask

  initial begin
    logic [KEY_W-1:0] masks [5];
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CMD_ADD;
    site_key_i = '0;
    neighbor_a_i = '0;
    neighbor_b_i = '0;
    neighbor_c_i = '0;
    neighbor_d_i = '0;
    neighbor_valid_i = '0;
    read_site_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    site_count = 0;
    burst_left = 0;
    masks[0] = 32'h0000_0000;
    masks[1] = 32'hFFFF_0000;
    masks[2] = 32'h0000_000F;
    masks[3] = $urandom;
    masks[4] = 32'hFFFF_FFFF;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset mask of all ones.
    read_site(0);                                            // read before any add
    add_site(32'hFFFF_FFFF, 10'd0, 10'd0, 4'hF);             // site 0 takes label 1
    add_site(32'h0000_0000, 10'd0, 10'd0, 4'hF);             // key differs: fresh label
    add_site(32'h0000_0000, 10'd1, 10'd0, 4'h1);             // one link: copies label
    add_site(32'hFFFF_FFFF, 10'd3, 10'd1023, 4'h3);          // self and later neighbors
    add_site(32'hFFFF_FFFF, 10'd0, 10'd4, 4'h0);             // no valid neighbor
    add_site(32'h0000_0000, 10'd2, 10'd1, 4'h3);             // two links, same root
    issue(CMD_ADD, 32'hFFFF_FFFF, 10'd0, 10'd4, 10'd3, 10'd5, 4'hF, '0); // merge
    issue(CMD_ADD, 32'h0000_0000, 10'd1023, 10'd1023, 10'd2, 10'd6, 4'hC, '0);
    read_site(10'd5);
    read_site(10'd4);
    read_site(10'd7);                                        // last added site
    read_site(10'd8);                                        // one past the end
    read_site(10'd1023);
    issue(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1);           // unused command
    issue(CMD_RESTART, '0, '0, '0, '0, '0, '0, '0);
    read_site(0);                                            // empty again after restart
    add_site(32'h1234_5678, 10'd0, 10'd0, 4'h0);

    // Random phases, each under a mask from the list, entered only with the block idle.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      write_mask(masks[phase % 5]);
      new_pass();
      if (phase == 3) begin
        // A full pass up to capacity, then adds that must be turned away, then mixed items.
        while (site_count < SITES_DEF) random_item(1'b1);
        repeat (6) random_item(1'b1);
        repeat (30) random_item(1'b0);
      end else begin
        repeat (45) random_item(1'b0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("cluster_labeler_union_find test passed");
    end else begin
      $display("cluster_labeler_union_find test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of long class chains.
  initial begin
    #200000000;
    $display("cluster_labeler_union_find test failed");
    $finish;
  end
endmodule
